>>> rtl/dgm_pkg.sv
// Shared types, constants and helper functions of the delay and gain mixer.
// Used by the channel interfaces, the lanes, the merge stage and the top level.
// No dependencies.
package dgm_pkg;

  // Field widths fixed by the frame format.
  localparam int SAMPLE_W     = 24;
  localparam int DELAY_W      = 10;
  localparam int GAIN_W       = 16;
  localparam int PROD_W       = SAMPLE_W + GAIN_W;
  localparam int ACC_W        = PROD_W + 2;
  localparam int FRAC_W       = 15;
  localparam int RES_W        = ACC_W - FRAC_W;
  localparam int INPUT_COUNT  = 4;
  localparam int OUTPUT_COUNT = 2;
  localparam int CFG_IDX_W    = 4;

  // Default history length in frames.
  localparam int HISTORY_DEPTH_DEF = 1024;

  // Rounding bias for the Q1.15 to integer conversion (one half).
  localparam int ROUND_BIAS = 1 << (FRAC_W - 1);

  // Saturation limits of a 24-bit sample.
  localparam int SAT_MAX = (1 << (SAMPLE_W - 1)) - 1;
  localparam int SAT_MIN = -(1 << (SAMPLE_W - 1));

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [DELAY_W-1:0]  delay_t;
  typedef logic        [GAIN_W-1:0]   gain_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LEFT_IN0  = 4'd0,
    REG_DELAY_LEFT_IN1  = 4'd1,
    REG_DELAY_LEFT_IN2  = 4'd2,
    REG_DELAY_LEFT_IN3  = 4'd3,
    REG_DELAY_RIGHT_IN0 = 4'd4,
    REG_DELAY_RIGHT_IN1 = 4'd5,
    REG_DELAY_RIGHT_IN2 = 4'd6,
    REG_DELAY_RIGHT_IN3 = 4'd7
  } dgm_reg_e;

  localparam int REG_COUNT = OUTPUT_COUNT * INPUT_COUNT;

  // Reset values of the delay registers, in register map order.
  localparam delay_t DELAY_RESET [REG_COUNT] = '{
    10'd0, 10'd0, 10'd96, 10'd240, 10'd240, 10'd96, 10'd0, 10'd0
  };

  // Fixed Q1.15 gains: first index is the output side, second the input.
  localparam gain_t GAIN_Q15 [OUTPUT_COUNT][INPUT_COUNT] = '{
    '{16'd32768, 16'd29491, 16'd26214, 16'd22938},
    '{16'd22938, 16'd26214, 16'd29491, 16'd32768}
  };

  // Pipeline advance and write strobes shared by the lanes and the merge stage.
  typedef struct packed {
    logic wr_en;
    logic en1;
    logic en2;
    logic en3;
    logic en_out;
  } dgm_ctl_t;

  // Reduces a delay modulo the history depth by restoring subtraction.
  // The depth is at least 16, so six steps cover any 10-bit delay.
  function automatic delay_t delay_mod(input delay_t d, input int unsigned depth);
    delay_t v;
    v = d;
    for (int k = 5; k >= 0; k--) begin
      if (32'(v) >= (depth << k)) begin
        v = v - DELAY_W'(depth << k);
      end
    end
    return v;
  endfunction

endpackage

>>> rtl/dgm_frame_if.sv
// Valid/ready channel interfaces for input frames and mixed output frames.
// Depends on dgm_pkg for the sample type.
interface dgm_in_if;
  import dgm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in0;
  sample_t sample_in1;
  sample_t sample_in2;
  sample_t sample_in3;

  modport source (output valid, output sample_in0, output sample_in1,
                  output sample_in2, output sample_in3, input ready);
  modport sink   (input valid, input sample_in0, input sample_in1,
                  input sample_in2, input sample_in3, output ready);
endinterface

interface dgm_out_if;
  import dgm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_left;
  sample_t sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink   (input valid, input sample_left, input sample_right, output ready);
endinterface

>>> rtl/dgm_lane.sv
// One input lane: history memory with two tap reads, current-frame bypass,
// unwritten-slot masking and the left and right gain multipliers.
// Depends on dgm_pkg.
module dgm_lane #(
  parameter int HISTORY_DEPTH = dgm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                 clk,
  input  dgm_pkg::dgm_ctl_t                    ctl,
  input  logic [$clog2(HISTORY_DEPTH)-1:0]     wr_addr,
  input  logic [$clog2(HISTORY_DEPTH+1)-1:0]   fill,
  input  dgm_pkg::sample_t                     sample_in,
  input  dgm_pkg::delay_t                      delay_left,
  input  dgm_pkg::delay_t                      delay_right,
  input  dgm_pkg::gain_t                       gain_left,
  input  dgm_pkg::gain_t                       gain_right,
  output dgm_pkg::prod_t                       prod_left,
  output dgm_pkg::prod_t                       prod_right
);
  import dgm_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = ((AW > DELAY_W) ? AW : DELAY_W) + 2;

  sample_t hist_r [HISTORY_DEPTH];

  logic [AW-1:0] addr_left;
  logic [AW-1:0] addr_right;
  logic          ok_left;
  logic          ok_right;

  sample_t rd_left_r;
  sample_t rd_right_r;
  sample_t cur_r;
  logic    byp_left_r;
  logic    byp_right_r;
  logic    ok_left_r;
  logic    ok_right_r;

  sample_t                    tap_left;
  sample_t                    tap_right;
  logic signed [PROD_W:0]     full_left;
  logic signed [PROD_W:0]     full_right;
  prod_t                      prod_left_r;
  prod_t                      prod_right_r;

  // Slot index of a tap: write pointer minus delay, wrapped into the history.
  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp, input delay_t d);
    logic signed [CW-1:0] diff;
    diff = $signed(CW'(wp)) - $signed(CW'(d));
    if (diff < 0) begin
      diff = diff + $signed(CW'(HISTORY_DEPTH));
    end
    return diff[AW-1:0];
  endfunction

  // Tap addresses, and whether the tapped slot has been written since reset.
  always_comb begin
    addr_left  = tap_addr(wr_addr, delay_left);
    addr_right = tap_addr(wr_addr, delay_right);
    ok_left    = CW'(delay_left) <= CW'(fill);
    ok_right   = CW'(delay_right) <= CW'(fill);
  end

  // History memory: one write and two registered reads per frame.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      hist_r[wr_addr] <= sample_in;
    end
    if (ctl.en1) begin
      rd_left_r  <= hist_r[addr_left];
      rd_right_r <= hist_r[addr_right];
    end
  end

  // Side information that travels with the read data.
  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      cur_r       <= sample_in;
      byp_left_r  <= delay_left == '0;
      byp_right_r <= delay_right == '0;
      ok_left_r   <= ok_left;
      ok_right_r  <= ok_right;
    end
  end

  // A zero delay takes the current frame; unwritten slots read as zero.
  always_comb begin
    tap_left   = byp_left_r ? cur_r : (ok_left_r ? rd_left_r : '0);
    tap_right  = byp_right_r ? cur_r : (ok_right_r ? rd_right_r : '0);
    full_left  = tap_left * $signed({1'b0, gain_left});
    full_right = tap_right * $signed({1'b0, gain_right});
  end

  // Product registers.
  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      prod_left_r  <= full_left[PROD_W-1:0];
      prod_right_r <= full_right[PROD_W-1:0];
    end
  end

  assign prod_left  = prod_left_r;
  assign prod_right = prod_right_r;

endmodule

>>> rtl/dgm_merge.sv
// Merge stage: sums the lane products per output side, then rounds the
// Q1.15 sum to an integer and saturates it into the output register.
// Depends on dgm_pkg.
module dgm_merge (
  input  logic              clk,
  input  dgm_pkg::dgm_ctl_t ctl,
  input  dgm_pkg::prod_t    prod_left  [dgm_pkg::INPUT_COUNT],
  input  dgm_pkg::prod_t    prod_right [dgm_pkg::INPUT_COUNT],
  output dgm_pkg::sample_t  sample_left,
  output dgm_pkg::sample_t  sample_right
);
  import dgm_pkg::*;

  acc_t    sum_left;
  acc_t    sum_right;
  acc_t    acc_left_r;
  acc_t    acc_right_r;
  sample_t sat_left;
  sample_t sat_right;
  sample_t sample_left_r;
  sample_t sample_right_r;

  // Round to nearest, half toward plus infinity, then clamp to 24 bits.
  function automatic sample_t round_sat(input acc_t acc);
    acc_t                    shifted;
    logic signed [RES_W-1:0] r;
    shifted = acc >>> FRAC_W;
    r       = shifted[RES_W-1:0];
    if (r > $signed(RES_W'(SAT_MAX))) begin
      return sample_t'(SAT_MAX);
    end else if (r < $signed(RES_W'(SAT_MIN))) begin
      return sample_t'(SAT_MIN);
    end
    return r[SAMPLE_W-1:0];
  endfunction

  // Sum of the four lanes plus the rounding bias.
  always_comb begin
    sum_left  = acc_t'(ROUND_BIAS);
    sum_right = acc_t'(ROUND_BIAS);
    for (int i = 0; i < INPUT_COUNT; i++) begin
      sum_left  = sum_left + ACC_W'(prod_left[i]);
      sum_right = sum_right + ACC_W'(prod_right[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      acc_left_r  <= sum_left;
      acc_right_r <= sum_right;
    end
  end

  // Output register.
  always_comb begin
    sat_left  = round_sat(acc_left_r);
    sat_right = round_sat(acc_right_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      sample_left_r  <= sat_left;
      sample_right_r <= sat_right;
    end
  end

  assign sample_left  = sample_left_r;
  assign sample_right = sample_right_r;

endmodule

>>> rtl/four_in_two_out_delay_gain_mixer.sv
// Four-in, two-out delay and gain mixer: top level with the delay registers,
// write pointer, pipeline control, four lanes and the merge stage.
// Depends on dgm_pkg, dgm_frame_if, dgm_lane and dgm_merge.
//
// Usage:
//   A request on in_frame carries one frame of four signed 24-bit samples.
//   A request on out_frame carries the left and right mix of that frame,
//   each the sum of four delayed inputs times fixed gains, rounded and
//   saturated to 24 bits. Exactly one output frame leaves per input frame.
//   Delays are set through cfg_we, cfg_index and cfg_data; index 0..3 are the
//   left delays of inputs 0..3, index 4..7 the right ones, other indexes are
//   ignored. A delay takes effect on the next frame and wraps at the
//   history depth.
//   The pipeline has four register stages: history read, multiply, lane
//   sum, round and saturate. out_frame.valid rises when the frame reaches
//   the output register after the read, multiply and sum registers. One
//   frame is accepted per cycle while in_frame.ready is high; each lane's
//   memory serves one write and two tap reads in that cycle.
//   Reset (rst_n low, synchronous) loads the default delays, empties the
//   pipeline and marks the whole history as unwritten, so taps read zero
//   until frames have filled them; no clearing pass is needed.
//   When out_frame stalls, the result holds in the output register and the
//   earlier stages keep filling; in_frame.ready drops only once all four
//   stages hold a frame.
module four_in_two_out_delay_gain_mixer #(
  parameter int HISTORY_DEPTH = dgm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  dgm_in_if.sink                          in_frame,
  dgm_out_if.source                       out_frame,
  input  logic                            cfg_we,
  input  logic [dgm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dgm_pkg::DELAY_W-1:0]     cfg_data
);
  import dgm_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int RIW = $clog2(REG_COUNT);

  delay_t        delay_r [REG_COUNT];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_nxt;
  logic [FW-1:0] fill_r;
  logic [FW-1:0] fill_nxt;
  logic          v1_r;
  logic          v2_r;
  logic          v3_r;
  logic          vo_r;
  logic          accept;
  dgm_ctl_t      ctl;

  sample_t samples    [INPUT_COUNT];
  prod_t   prod_left  [INPUT_COUNT];
  prod_t   prod_right [INPUT_COUNT];

  // Delay registers, stored already reduced modulo the history depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        delay_r[i] <= delay_mod(DELAY_RESET[i], HISTORY_DEPTH);
      end
    end else if (cfg_we && (32'(cfg_index) < REG_COUNT)) begin
      delay_r[cfg_index[RIW-1:0]] <= delay_mod(cfg_data, HISTORY_DEPTH);
    end
  end

  // Pipeline advance: a stage moves when the next one is empty or moving.
  always_comb begin
    ctl.en_out = !vo_r || out_frame.ready;
    ctl.en3    = !v3_r || ctl.en_out;
    ctl.en2    = !v2_r || ctl.en3;
    ctl.en1    = !v1_r || ctl.en2;
    accept     = in_frame.valid && ctl.en1;
    ctl.wr_en  = accept;
  end

  assign in_frame.ready = ctl.en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ctl.en1) v1_r <= in_frame.valid;
      if (ctl.en2) v2_r <= v1_r;
      if (ctl.en3) v3_r <= v2_r;
      if (ctl.en_out) vo_r <= v3_r;
    end
  end

  // Write pointer and count of written slots, saturating at the depth.
  always_comb begin
    wp_nxt   = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    fill_nxt = (fill_r == FW'(HISTORY_DEPTH)) ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (accept) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign samples[0] = in_frame.sample_in0;
  assign samples[1] = in_frame.sample_in1;
  assign samples[2] = in_frame.sample_in2;
  assign samples[3] = in_frame.sample_in3;

  // One lane per input channel.
  for (genvar g = 0; g < INPUT_COUNT; g++) begin : g_lane
    dgm_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_lane (
      .clk         (clk),
      .ctl         (ctl),
      .wr_addr     (wp_r),
      .fill        (fill_r),
      .sample_in   (samples[g]),
      .delay_left  (delay_r[int'(REG_DELAY_LEFT_IN0) + g]),
      .delay_right (delay_r[int'(REG_DELAY_RIGHT_IN0) + g]),
      .gain_left   (GAIN_Q15[0][g]),
      .gain_right  (GAIN_Q15[1][g]),
      .prod_left   (prod_left[g]),
      .prod_right  (prod_right[g])
    );
  end

  dgm_merge u_merge (
    .clk          (clk),
    .ctl          (ctl),
    .prod_left    (prod_left),
    .prod_right   (prod_right),
    .sample_left  (out_frame.sample_left),
    .sample_right (out_frame.sample_right)
  );

  assign out_frame.valid = vo_r;

endmodule

>>> rtl/dgm_checker.sv
// Port-level checks of the mixer's handshakes and pipeline occupancy,
// bound to the top level. Depends on dgm_pkg for field widths.
module dgm_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input dgm_pkg::sample_t sample_left,
  input dgm_pkg::sample_t sample_right
);
  import dgm_pkg::*;

  logic [2:0] inflight_r;
  logic [2:0] inflight_nxt;

  // Frames accepted but not yet delivered.
  always_comb begin
    inflight_nxt = inflight_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // A waiting result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped before it was taken");

  // A waiting result keeps its samples.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sample_left) && $stable(sample_right))
    else $error("output samples changed while stalled");

  // The pipeline holds at most four frames and takes input while any stage is free.
  a_free_stage: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r < 3'd4 |-> in_ready)
    else $error("input stalled with a free pipeline stage");

  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd4)
    else $error("more frames in flight than pipeline stages");

  // No result without a frame that caused it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("output offered with no frame in flight");

endmodule

bind four_in_two_out_delay_gain_mixer dgm_checker u_dgm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_frame.valid),
  .in_ready     (in_frame.ready),
  .out_valid    (out_frame.valid),
  .out_ready    (out_frame.ready),
  .sample_left  (out_frame.sample_left),
  .sample_right (out_frame.sample_right)
);

>>> sim/four_in_two_out_delay_gain_mixer_tb.sv
// Self-checking testbench for the four-in, two-out delay and gain mixer.
// Needs dgm_pkg, the dgm_in_if/dgm_out_if channel interfaces and the mixer RTL.
// A directed table runs first, then several delay profiles with random frames.
module four_in_two_out_delay_gain_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dgm_pkg::*;

  localparam int HIST_FRAMES    = 1024;
  localparam int CHANNELS       = 4;
  localparam int FRAC_BITS      = 15;
  localparam longint HALF_LSB   = 64'sd16384;
  localparam longint PEAK_POS   = 64'sd8388607;
  localparam longint PEAK_NEG   = -64'sd8388608;
  localparam int FRAMES_PER_SET = 325;
  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 1000;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP = '1;

  localparam sample_t ZERO  = 24'sd0;
  localparam sample_t S_MAX = 24'sh7FFFFF;
  localparam sample_t S_MIN = 24'sh800000;

  // Q1.15 gains per side: left row first, then right.
  localparam int MIX_GAIN [2][CHANNELS] = '{
    '{32768, 29491, 26214, 22938},
    '{22938, 26214, 29491, 32768}
  };

  // Delay profiles used between random sets.
  typedef enum int {DLY_ZERO, DLY_FULL, DLY_SHORT, DLY_ANY, DLY_EDGES} delay_profile_e;
  localparam int SET_COUNT = 6;
  localparam delay_profile_e SET_PROFILE [SET_COUNT] = '{
    DLY_ZERO, DLY_FULL, DLY_SHORT, DLY_ANY, DLY_EDGES, DLY_ANY
  };

  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_mix_t;

  typedef struct packed {
    logic    typed;
    sample_t in0;
    sample_t in1;
    sample_t in2;
    sample_t in3;
    sample_t left;
    sample_t right;
  } frame_row_t;

  // Directed frames, sent right after reset with the default delays.
  // Rows marked typed carry their answer; the rest go through the predictor.
  localparam int DIRECTED_ROWS = 15;
  localparam frame_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, ZERO, ZERO, ZERO, ZERO, ZERO, ZERO},
    '{1'b1, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX},
    '{1'b1, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN},
    '{1'b1, 24'sd1000, ZERO, ZERO, ZERO, 24'sd1000, ZERO},
    '{1'b1, ZERO, ZERO, ZERO, -24'sd1000, ZERO, -24'sd1000},
    '{1'b0, S_MAX, S_MIN, ZERO, ZERO, ZERO, ZERO},
    '{1'b0, ZERO, 24'sd1, ZERO, ZERO, ZERO, ZERO},
    '{1'b0, ZERO, -24'sd1, ZERO, ZERO, ZERO, ZERO},
    '{1'b0, ZERO, 24'sd16384, ZERO, ZERO, ZERO, ZERO},
    '{1'b0, ZERO, -24'sd16384, ZERO, ZERO, ZERO, ZERO},
    '{1'b0, ZERO, ZERO, S_MAX, ZERO, ZERO, ZERO},
    '{1'b0, 24'sd1, 24'sd1, 24'sd1, 24'sd1, ZERO, ZERO},
    '{1'b0, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, ZERO, ZERO},
    '{1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, ZERO, ZERO},
    '{1'b0, S_MIN, S_MAX, S_MIN, S_MAX, ZERO, ZERO}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DELAY_W-1:0]   cfg_data;

  dgm_in_if  in_if ();
  dgm_out_if out_if ();

  four_in_two_out_delay_gain_mixer #(
    .HISTORY_DEPTH (HIST_FRAMES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_frame  (in_if),
    .out_frame (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Mirror of the mixer state.
  sample_t            history [CHANNELS][HIST_FRAMES];
  logic [DELAY_W-1:0] head;
  logic [DELAY_W-1:0] tap_delay [2*CHANNELS];

  stereo_mix_t mix_expected_q [$];
  frame_row_t  frame_rows_q [$];
  int          mismatch_count;
  int          quiet_cycles;
  bit          src_steady;
  bit          sink_steady;
  int          sink_hold;

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return sample_t'(int'($urandom_range(0, 200)) - 100);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // One side of the mix: gather the four taps, scale, round half up, clip.
  function automatic sample_t side_sum(input int side);
    longint             acc;
    longint             r;
    logic [DELAY_W-1:0] slot;
    acc = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      slot = head - tap_delay[side*CHANNELS + i];
      acc += longint'(history[i][slot]) * longint'(MIX_GAIN[side][i]);
    end
    r = (acc + HALF_LSB) >>> FRAC_BITS;
    if (r > PEAK_POS) r = PEAK_POS;
    if (r < PEAK_NEG) r = PEAK_NEG;
    return sample_t'(r);
  endfunction

  // Store the frame at the write slot, mix both sides, then advance the slot.
  function automatic stereo_mix_t predict_mix(input sample_t a, b, c, d);
    stereo_mix_t m;
    history[0][head] = a;
    history[1][head] = b;
    history[2][head] = c;
    history[3][head] = d;
    m.left  = side_sum(0);
    m.right = side_sum(1);
    head    = head + 1'b1;
    return m;
  endfunction

  // Sender: optional gap, then hold the request until it is taken.
  task automatic send_frame(input frame_row_t row);
    int gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_rows_q.push_back(row);
    in_if.valid      <= 1'b1;
    in_if.sample_in0 <= row.in0;
    in_if.sample_in1 <= row.in1;
    in_if.sample_in2 <= row.in2;
    in_if.sample_in3 <= row.in3;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_delay(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Let every outstanding result come back, then give the pipeline time to empty.
  // The first edge lets the scoreboard record the last accepted request.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (mix_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls on the output channel.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_if.ready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (!sink_steady) sink_hold = pick_gap();
    end
  end

  // Scoreboard: config mirror, prediction on input requests, check on outputs.
  always @(posedge clk) begin : scoreboard
    frame_row_t  row;
    stereo_mix_t want;
    stereo_mix_t got;
    if (rst_n) begin
      if (cfg_we && cfg_index < REG_COUNT) tap_delay[cfg_index[2:0]] = cfg_data;

      if (in_if.valid && in_if.ready) begin
        want = predict_mix(in_if.sample_in0, in_if.sample_in1,
                           in_if.sample_in2, in_if.sample_in3);
        row = frame_rows_q.pop_front();
        if (row.typed) begin
          want.left  = row.left;
          want.right = row.right;
        end
        mix_expected_q.push_back(want);
      end

      if (out_if.valid && out_if.ready) begin
        got.left  = out_if.sample_left;
        got.right = out_if.sample_right;
        if (mix_expected_q.size() == 0) begin
          $display("%0t: unexpected output frame left %0d right %0d",
                   $time, got.left, got.right);
          mismatch_count++;
        end else begin
          want = mix_expected_q.pop_front();
          if (got.left !== want.left) begin
            $display("%0t: left mismatch, expected %0d, got %0d",
                     $time, want.left, got.left);
            mismatch_count++;
          end
          if (got.right !== want.right) begin
            $display("%0t: right mismatch, expected %0d, got %0d",
                     $time, want.right, got.right);
            mismatch_count++;
          end
        end
      end

      // Watchdog on cycles with no request moving on either channel.
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    frame_row_t         row;
    logic [DELAY_W-1:0] d;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.sample_in0 = '0;
    in_if.sample_in1 = '0;
    in_if.sample_in2 = '0;
    in_if.sample_in3 = '0;
    out_if.ready     = 1'b0;
    mismatch_count   = 0;
    quiet_cycles     = 0;
    sink_hold        = 0;
    src_steady       = 1'b0;
    sink_steady      = 1'b0;
    head             = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      for (int j = 0; j < HIST_FRAMES; j++) history[i][j] = ZERO;
    end
    tap_delay = '{10'd0, 10'd0, 10'd96, 10'd240, 10'd240, 10'd96, 10'd0, 10'd0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames with the reset delays.
    for (int n = 0; n < DIRECTED_ROWS; n++) send_frame(DIRECTED[n]);
    drain();

    // Random sets, each under its own delay profile.
    for (int p = 0; p < SET_COUNT; p++) begin
      for (int k = 0; k < REG_COUNT; k++) begin
        case (SET_PROFILE[p])
          DLY_ZERO:  d = '0;
          DLY_FULL:  d = '1;
          DLY_SHORT: d = DELAY_W'($urandom_range(0, 15));
          DLY_EDGES: d = $urandom_range(0, 1) ? '1 : '0;
          default:   d = DELAY_W'($urandom());
        endcase
        write_delay(dgm_reg_e'(k), d);
      end
      // An index past the register map must leave every delay alone.
      write_delay(CFG_IDX_W'($urandom_range(REG_COUNT, IDX_TOP)), DELAY_W'($urandom()));
      cfg_we <= 1'b0;

      src_steady  = (SET_PROFILE[p] == DLY_FULL);
      sink_steady = (SET_PROFILE[p] == DLY_FULL);
      for (int n = 0; n < FRAMES_PER_SET; n++) begin
        row.typed = 1'b0;
        row.in0   = rand_sample();
        row.in1   = rand_sample();
        row.in2   = rand_sample();
        row.in3   = rand_sample();
        row.left  = ZERO;
        row.right = ZERO;
        send_frame(row);
      end
      src_steady  = 1'b0;
      sink_steady = 1'b0;
      drain();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dgm_pkg.sv
rtl/dgm_frame_if.sv
rtl/dgm_lane.sv
rtl/dgm_merge.sv
rtl/four_in_two_out_delay_gain_mixer.sv
rtl/dgm_checker.sv
sim/four_in_two_out_delay_gain_mixer_tb.sv
